### rtl/core/crc8sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8sfr_pkg
// Shared types, frame constants and the crc-8 step of the serial frame receiver.
// ----------------------------------------------------------------------------
package crc8sfr_pkg;

    // frame layout
    localparam int unsigned PAYLOAD_BYTES_DEF = 10;
    localparam int unsigned PAYLOAD_MAX_BYTES = 10;

    localparam logic [7:0] SYNC1_BYTE = 8'h55;
    localparam logic [7:0] SYNC2_BYTE = 8'hAA;
    localparam logic [7:0] CTRL_RX_BYTE = 8'h01;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [7:0] CRC_OFF = 8'h00;

    // configuration
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    // item command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_GOOD_FRAME = 3'd1,
        EV_CRC_FAIL   = 3'd2,
        EV_TICK_FRAME = 3'd3,
        EV_TICK_IDLE  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CTRL  = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRC   = 3'd4,
        PH_SEQ   = 3'd5,
        PH_TAIL  = 3'd6
    } phase_t;

    // parser status seen by the frame bookkeeping
    typedef struct packed {
        logic frame_end;   // good tail byte taken this cycle
        logic crc_ok;      // crc check of the frame in flight passed
    } parse_stat_t;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/crc8sfr_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8sfr_in_if
// Input item channel: command and received byte with valid/ready.
// ----------------------------------------------------------------------------
interface crc8sfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/core/crc8sfr_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8sfr_out_if
// Result item channel: event code and latched frame state with valid/ready.
// ----------------------------------------------------------------------------
interface crc8sfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [63:0] payload_low;
    logic [15:0] payload_high;
    logic [7:0]  crc_field;
    logic [7:0]  sequence_field;
    logic [31:0] frames_total;
    logic [31:0] crc_errors_total;
    logic        link_up;
    logic        frame_pending;

    modport source (
        output valid, output event_res, output payload_low, output payload_high,
        output crc_field, output sequence_field, output frames_total,
        output crc_errors_total, output link_up, output frame_pending,
        input ready
    );
    modport sink (
        input valid, input event_res, input payload_low, input payload_high,
        input crc_field, input sequence_field, input frames_total,
        input crc_errors_total, input link_up, input frame_pending,
        output ready
    );
endinterface
`default_nettype wire

### rtl/core/crc8sfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8sfr_parser
// Byte-level frame parser: sync, control, payload, crc, sequence and tail.
// ----------------------------------------------------------------------------
module crc8sfr_parser
    import crc8sfr_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       byte_en,
    input  wire logic [7:0]                 rx_byte,
    output parse_stat_t                     stat,
    output logic [PAYLOAD_BYTES*8-1:0]      work_payload,
    output logic [7:0]                      work_crc,
    output logic [7:0]                      work_sequence
);

    localparam int unsigned PW = PAYLOAD_BYTES * 8;
    localparam int unsigned CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PAYLOAD_BYTES - 1);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         crc_reg, crc_next;
    logic               crc_ok_reg, crc_ok_next;
    logic [PW-1:0]      payload_reg, payload_next;
    logic [7:0]         wcrc_reg, wcrc_next;
    logic [7:0]         wseq_reg, wseq_next;
    logic               is_sync1;

    assign is_sync1 = (rx_byte == SYNC1_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            cnt_reg    <= '0;
            crc_reg    <= CRC_INIT;
            crc_ok_reg <= 1'b0;
        end
        else if (byte_en)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            crc_reg    <= crc_next;
            crc_ok_reg <= crc_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            payload_reg <= payload_next;
            wcrc_reg    <= wcrc_next;
            wseq_reg    <= wseq_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        crc_next     = crc_reg;
        crc_ok_next  = crc_ok_reg;
        payload_next = payload_reg;
        wcrc_next    = wcrc_reg;
        wseq_next    = wseq_reg;
        stat.frame_end = 1'b0;
        stat.crc_ok    = crc_ok_reg;

        case (phase_reg)
            PH_SYNC1:
            begin
                if (is_sync1)
                begin
                    crc_next   = crc8_step(CRC_INIT, rx_byte);
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2, PH_CTRL:
            begin
                if ((phase_reg == PH_SYNC2 && rx_byte == SYNC2_BYTE) ||
                    (phase_reg == PH_CTRL && rx_byte == CTRL_RX_BYTE))
                begin
                    crc_next   = crc8_step(crc_reg, rx_byte);
                    cnt_next   = '0;
                    phase_next = (phase_reg == PH_SYNC2) ? PH_CTRL : PH_DATA;
                end
                else
                begin
                    // resync on a fresh sync byte, else start over
                    crc_ok_next = 1'b0;
                    crc_next    = is_sync1 ? crc8_step(CRC_INIT, rx_byte) : CRC_INIT;
                    phase_next  = is_sync1 ? PH_SYNC2 : PH_SYNC1;
                end
            end
            PH_DATA:
            begin
                // bytes shift in from the top, byte 0 ends at the bottom
                payload_next = (payload_reg >> 8) | (PW'(rx_byte) << (PW - 8));
                crc_next     = crc8_step(crc_reg, rx_byte);
                if (cnt_reg == LAST_IDX)
                    phase_next = PH_CRC;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            PH_CRC:
            begin
                wcrc_next   = rx_byte;
                crc_ok_next = (rx_byte == CRC_OFF) || (rx_byte == crc_reg);
                phase_next  = PH_SEQ;
            end
            PH_SEQ:
            begin
                wseq_next  = rx_byte;
                phase_next = PH_TAIL;
            end
            PH_TAIL:
            begin
                stat.frame_end = byte_en && (rx_byte == TAIL_BYTE);
                crc_ok_next    = 1'b0;
                crc_next       = is_sync1 ? crc8_step(CRC_INIT, rx_byte) : CRC_INIT;
                phase_next     = is_sync1 ? PH_SYNC2 : PH_SYNC1;
            end
            default:
            begin
                crc_ok_next = 1'b0;
                crc_next    = CRC_INIT;
                phase_next  = PH_SYNC1;
            end
        endcase
    end

    assign work_payload  = payload_reg;
    assign work_crc      = wcrc_reg;
    assign work_sequence = wseq_reg;

endmodule
`default_nettype wire

### rtl/core/crc8_serial_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_serial_frame_receiver_core
// Serial frame receiver with crc-8 check, frame latch and link timeout.
// ----------------------------------------------------------------------------
//  channel      dir  handshake       contents
//  item_in      in   valid/ready     cmd (byte or tick), rx_byte
//  result_out   out  valid/ready     event_res and the latched frame state
//  apb          in   psel/penable    timeout_ticks at addresses 0 to 3
//
//  one item per cycle while item_in.ready is high; its result shows in the cycle after acceptance
//  the crc-8 byte step and the frame bookkeeping settle in the cycle the item is accepted
//  item_in.ready drops only while a result sits unaccepted in the result register
//  asynchronous active-low reset: parser waits for the first sync byte,
//  counters and latched frame clear, silence count starts at the timeout reset
// ----------------------------------------------------------------------------
module crc8_serial_frame_receiver_core
    import crc8sfr_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    crc8sfr_in_if.sink                  item_in,
    crc8sfr_out_if.source               result_out,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned PW = PAYLOAD_BYTES * 8;
    localparam int unsigned FULL_W = PAYLOAD_MAX_BYTES * 8;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [7:0] timeout_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[APB_ADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_wr)
            timeout_reg <= pwdata[7:0];
    end

    assign prdata = paddr[APB_ADDR_W-1] ? 32'd0 : 32'(timeout_reg);

    // ------------------------------------------------------------------
    // input handshake: take an item whenever the result slot is free
    // or being emptied this cycle
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic accept;
    logic byte_en;
    logic tick_en;

    assign item_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = item_in.valid && item_in.ready;
    assign byte_en       = accept && (item_in.cmd == CMD_BYTE);
    assign tick_en       = accept && (item_in.cmd == CMD_TICK);

    // ------------------------------------------------------------------
    // byte parser
    // ------------------------------------------------------------------
    parse_stat_t    stat;
    logic [PW-1:0]  work_payload;
    logic [7:0]     work_crc;
    logic [7:0]     work_sequence;

    crc8sfr_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (byte_en),
        .rx_byte       (item_in.rx_byte),
        .stat          (stat),
        .work_payload  (work_payload),
        .work_crc      (work_crc),
        .work_sequence (work_sequence)
    );

    // ------------------------------------------------------------------
    // frame latch, counters and link state
    // ------------------------------------------------------------------
    logic [PW-1:0]  held_payload_reg;
    logic [7:0]     held_crc_reg;
    logic [7:0]     held_seq_reg;
    logic           pending_reg, pending_next;
    logic           connected_reg, connected_next;
    logic [7:0]     silence_reg, silence_next;
    logic [31:0]    frames_reg, frames_next;
    logic [31:0]    crc_fail_reg, crc_fail_next;
    event_t         event_reg, event_next;
    logic           latch_frame;
    logic [7:0]     silence_aged;

    // a tick with nothing pending ages the silence count up to the timeout
    assign silence_aged = (silence_reg < timeout_reg) ? silence_reg + 8'd1 : silence_reg;

    always_comb
    begin
        pending_next   = pending_reg;
        connected_next = connected_reg;
        silence_next   = silence_reg;
        frames_next    = frames_reg;
        crc_fail_next  = crc_fail_reg;
        event_next     = EV_NONE;
        latch_frame    = 1'b0;

        if (tick_en)
        begin
            if (pending_reg)
            begin
                pending_next   = 1'b0;
                connected_next = 1'b1;
                silence_next   = 8'd0;
                event_next     = EV_TICK_FRAME;
            end
            else
            begin
                silence_next = silence_aged;
                if (silence_aged >= timeout_reg)
                    connected_next = 1'b0;
                event_next = EV_TICK_IDLE;
            end
        end
        else if (stat.frame_end)
        begin
            // any good tail counts; only a passing crc latches the frame
            frames_next = frames_reg + 32'd1;
            if (stat.crc_ok)
            begin
                latch_frame    = 1'b1;
                pending_next   = 1'b1;
                connected_next = 1'b1;
                silence_next   = 8'd0;
                event_next     = EV_GOOD_FRAME;
            end
            else
            begin
                crc_fail_next = crc_fail_reg + 32'd1;
                event_next    = EV_CRC_FAIL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_payload_reg <= '0;
            held_crc_reg     <= 8'd0;
            held_seq_reg     <= 8'd0;
            pending_reg      <= 1'b0;
            connected_reg    <= 1'b0;
            silence_reg      <= TIMEOUT_RESET;
            frames_reg       <= 32'd0;
            crc_fail_reg     <= 32'd0;
            event_reg        <= EV_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pending_reg   <= pending_next;
                connected_reg <= connected_next;
                silence_reg   <= silence_next;
                frames_reg    <= frames_next;
                crc_fail_reg  <= crc_fail_next;
                event_reg     <= event_next;
            end
            if (latch_frame)
            begin
                held_payload_reg <= work_payload;
                held_crc_reg     <= work_crc;
                held_seq_reg     <= work_sequence;
            end
            // result slot: filled on accept, emptied when taken
            if (accept)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result item: state only moves on accept, so the state registers
    // together with the event register form the result register
    // ------------------------------------------------------------------
    logic [FULL_W-1:0] held_full;

    // unused payload bytes read as zero
    assign held_full = FULL_W'(held_payload_reg);

    assign result_out.valid            = out_valid_reg;
    assign result_out.event_res        = event_reg;
    assign result_out.payload_low      = held_full[63:0];
    assign result_out.payload_high     = held_full[79:64];
    assign result_out.crc_field        = held_crc_reg;
    assign result_out.sequence_field   = held_seq_reg;
    assign result_out.frames_total     = frames_reg;
    assign result_out.crc_errors_total = crc_fail_reg;
    assign result_out.link_up          = connected_reg;
    assign result_out.frame_pending    = pending_reg;

endmodule
`default_nettype wire

### tb/crc8_serial_frame_receiver_core_checker.sv
// ----------------------------------------------------------------------------
// crc8_serial_frame_receiver_core_checker
// Watches the item channels and the register port, predicts every result item
// from its own model of the frame parser and compares it field by field.
// ----------------------------------------------------------------------------
module crc8_serial_frame_receiver_core_checker
    import crc8sfr_pkg::*;
#(
    parameter logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = '0
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    crc8sfr_in_if                      item_in,
    crc8sfr_out_if                     result_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output int unsigned                mismatches,
    output int unsigned                owed
);

    typedef struct packed {
        event_t      ev;
        logic [63:0] lo;
        logic [15:0] hi;
        logic [7:0]  crc;
        logic [7:0]  seq;
        logic [31:0] frames;
        logic [31:0] errs;
        logic        link;
        logic        pend;
    } frame_status_t;

    // register copy
    logic [7:0]  timeout_ticks;

    // parser in flight
    phase_t      phase;
    logic [3:0]  data_idx;
    logic [7:0]  build_bytes [PAYLOAD_MAX_BYTES];
    logic [7:0]  crc_acc;
    logic [7:0]  crc_seen;
    logic [7:0]  seq_seen;
    logic        crc_pass;

    // latched frame and link bookkeeping
    logic [7:0]  held_bytes [PAYLOAD_MAX_BYTES];
    logic [7:0]  held_crc;
    logic [7:0]  held_seq;
    logic        pending;
    logic        link;
    logic [7:0]  silence;
    logic [31:0] frames;
    logic [31:0] crc_errs;

    frame_status_t owed_status [$];

    // bit-serial form of the msb-first crc-8 byte update
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        int         i;
        c = crc;
        for (i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    task automatic restart_parse();
        phase = PH_SYNC1;
        data_idx = '0;
        crc_seen = '0;
        seq_seen = '0;
        crc_acc = CRC_INIT;
        crc_pass = 1'b0;
    endtask

    task automatic resync_on(input logic [7:0] b);
        restart_parse();
        if (b == SYNC1_BYTE)
        begin
            crc_acc = crc8_next(CRC_INIT, b);
            phase = PH_SYNC2;
        end
    endtask

    task automatic reset_model();
        int i;
        timeout_ticks = TIMEOUT_RESET;
        for (i = 0; i < PAYLOAD_MAX_BYTES; i++)
        begin
            build_bytes[i] = '0;
            held_bytes[i] = '0;
        end
        held_crc = '0;
        held_seq = '0;
        pending = 1'b0;
        link = 1'b0;
        silence = TIMEOUT_RESET;
        frames = '0;
        crc_errs = '0;
        restart_parse();
    endtask

    task automatic advance_parser(input logic cmd, input logic [7:0] b, output frame_status_t s);
        event_t ev;
        int     i;
        ev = EV_NONE;
        if (cmd == CMD_TICK)
        begin
            if (pending)
            begin
                pending = 1'b0;
                link = 1'b1;
                silence = '0;
                ev = EV_TICK_FRAME;
            end
            else
            begin
                if (silence < timeout_ticks)
                    silence = silence + 8'd1;
                if (silence >= timeout_ticks)
                    link = 1'b0;
                ev = EV_TICK_IDLE;
            end
        end
        else
        begin
            case (phase)
                PH_SYNC1: resync_on(b);
                PH_SYNC2:
                    if (b == SYNC2_BYTE)
                    begin
                        crc_acc = crc8_next(crc_acc, b);
                        phase = PH_CTRL;
                    end
                    else
                        resync_on(b);
                PH_CTRL:
                    if (b == CTRL_RX_BYTE)
                    begin
                        for (i = 0; i < PAYLOAD_MAX_BYTES; i++)
                            build_bytes[i] = '0;
                        data_idx = '0;
                        crc_acc = crc8_next(crc_acc, b);
                        phase = PH_DATA;
                    end
                    else
                        resync_on(b);
                PH_DATA:
                begin
                    if (data_idx < PAYLOAD_MAX_BYTES)
                        build_bytes[data_idx] = b;
                    data_idx = data_idx + 4'd1;
                    crc_acc = crc8_next(crc_acc, b);
                    if (data_idx >= PAYLOAD_BYTES_DEF)
                        phase = PH_CRC;
                end
                PH_CRC:
                begin
                    crc_seen = b;
                    crc_pass = (b == CRC_OFF) || (b == crc_acc);
                    phase = PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_seen = b;
                    phase = PH_TAIL;
                end
                PH_TAIL:
                begin
                    if (b == TAIL_BYTE)
                    begin
                        frames = frames + 32'd1;
                        if (crc_pass)
                        begin
                            silence = '0;
                            for (i = 0; i < PAYLOAD_BYTES_DEF && i < PAYLOAD_MAX_BYTES; i++)
                                held_bytes[i] = build_bytes[i];
                            held_crc = crc_seen;
                            held_seq = seq_seen;
                            pending = 1'b1;
                            link = 1'b1;
                            ev = EV_GOOD_FRAME;
                        end
                        else
                        begin
                            crc_errs = crc_errs + 32'd1;
                            ev = EV_CRC_FAIL;
                        end
                    end
                    resync_on(b);
                end
                default: restart_parse();
            endcase
        end
        s.ev = ev;
        for (i = 0; i < 8; i++)
            s.lo[8*i +: 8] = held_bytes[i];
        s.hi = {held_bytes[9], held_bytes[8]};
        s.crc = held_crc;
        s.seq = held_seq;
        s.frames = frames;
        s.errs = crc_errs;
        s.link = link;
        s.pend = pending;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_status_t want;
        frame_status_t got;
        if (!rst_n)
        begin
            reset_model();
            owed_status.delete();
            mismatches = 0;
            owed = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
                timeout_ticks = pwdata[7:0];
            // results first: an item accepted now cannot show before the next edge
            if (result_out.valid && result_out.ready)
            begin
                if (owed_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with nothing expected", $time);
                end
                else
                begin
                    want = owed_status.pop_front();
                    got.ev = event_t'(result_out.event_res);
                    got.lo = result_out.payload_low;
                    got.hi = result_out.payload_high;
                    got.crc = result_out.crc_field;
                    got.seq = result_out.sequence_field;
                    got.frames = result_out.frames_total;
                    got.errs = result_out.crc_errors_total;
                    got.link = result_out.link_up;
                    got.pend = result_out.frame_pending;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch ev %0d/%0d frames %0d/%0d errs %0d/%0d",
                                     $time, want.ev, got.ev, want.frames, got.frames,
                                     want.errs, got.errs);
                            $display("    link %0b/%0b pend %0b/%0b crc %h/%h seq %h/%h",
                                     want.link, got.link, want.pend, got.pend,
                                     want.crc, got.crc, want.seq, got.seq);
                            $display("    payload %h_%h/%h_%h",
                                     want.hi, want.lo, got.hi, got.lo);
                        end
                    end
                end
            end
            if (item_in.valid && item_in.ready)
            begin
                advance_parser(item_in.cmd, item_in.rx_byte, want);
                owed_status.push_back(want);
            end
            owed = owed_status.size();
        end
    end

endmodule

### tb/crc8_serial_frame_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// crc8_serial_frame_receiver_core_tb
// Drives byte and tick items into the frame receiver under random idling on
// both channels, across several timeout settings, and gives the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
module crc8_serial_frame_receiver_core_tb;
    import crc8sfr_pkg::*;

    localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = '0;
    localparam int PHASE_ITEMS    = 145;   // random items per timeout setting
    localparam int LONG_TICK_RUN  = 260;   // enough idle ticks to saturate a 255 timeout
    localparam int HOLD_CYCLES    = 60;    // receiver hold-off that backs the block up
    localparam int DRAIN_LIMIT    = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned mismatches;
    int unsigned owed;

    // idling controls shared by the sender and the receiver processes
    bit tx_gaps_on;
    bit rx_stalls_on;
    int hold_len;
    int items_sent;

    crc8sfr_in_if  item_ch ();
    crc8sfr_out_if result_ch ();

    crc8_serial_frame_receiver_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    crc8_serial_frame_receiver_core_checker #(
        .TIMEOUT_ADDR (TIMEOUT_ADDR)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .owed       (owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL crc8_serial_frame_receiver_core");
        $finish;
    end

    // crc of a whole frame header plus payload, used to build good frames
    function automatic logic [7:0] frame_crc(input logic [79:0] body);
        logic [103:0] covered;
        logic [7:0]   c;
        logic         fb;
        int           k;
        int           i;
        covered = {body, CTRL_RX_BYTE, SYNC2_BYTE, SYNC1_BYTE};
        c = CRC_INIT;
        for (k = 0; k < 13; k++)
            for (i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ covered[8*k + i];
                c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
        return c;
    endfunction

    // sixteen frame bytes, byte 0 (first sync) in the lowest bits;
    // payload leans on the bytes the parser treats specially, crc is mostly good
    function automatic logic [127:0] build_random_frame(input logic [7:0] tail);
        logic [79:0] body;
        logic [7:0]  crc;
        int          i;
        int          r;
        for (i = 0; i < 10; i++)
        begin
            r = $urandom_range(0, 7);
            case (r)
                0:       body[8*i +: 8] = 8'h00;
                1:       body[8*i +: 8] = TAIL_BYTE;
                2:       body[8*i +: 8] = SYNC1_BYTE;
                default: body[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 65)
            crc = frame_crc(body);
        else if (r < 80)
            crc = CRC_OFF;
        else
            crc = frame_crc(body) ^ 8'($urandom_range(1, 255));
        return {tail, 8'($urandom_range(0, 255)), crc, body,
                CTRL_RX_BYTE, SYNC2_BYTE, SYNC1_BYTE};
    endfunction

    function automatic logic [7:0] random_tail();
        if ($urandom_range(0, 99) < 88)
            return TAIL_BYTE;
        return 8'($urandom_range(0, 254));
    endfunction

    // one item: optional idle gap, then hold valid until the block takes it
    task automatic push_item(input logic c, input logic [7:0] b);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            @(negedge clk) item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.rx_byte <= b;
        do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
        items_sent++;
    endtask

    task automatic send_bytes(input logic [127:0] f, input int start, input int count);
        int k;
        for (k = start; k < start + count; k++)
            push_item(CMD_BYTE, f[8*k +: 8]);
    endtask

    // sender pauses until every expected result item has been taken
    task automatic drain();
        @(negedge clk) item_ch.valid <= 1'b0;
        wait (owed == 0);
    endtask

    // setup cycle then access cycle, only with the block idle
    task automatic write_timeout(input logic [7:0] t);
        drain();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TIMEOUT_ADDR;
        pwdata <= {24'h0, t};
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly whole frames with random content, plus ticks, noise,
    // cut-off frames and a frame whose tail is a fresh sync byte
    task automatic random_chunk();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            tx_gaps_on = !tx_gaps_on;
            rx_stalls_on = ($urandom_range(0, 1) != 0);
        end
        if (pick < 50)
            send_bytes(build_random_frame(random_tail()), 0, 16);
        else if (pick < 62)
            repeat ($urandom_range(1, 4)) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
        else if (pick < 72)
            repeat ($urandom_range(1, 4)) push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        else if (pick < 86)
        begin
            n = $urandom_range(1, 15);
            send_bytes(build_random_frame(TAIL_BYTE), 0, n);
            if ($urandom_range(0, 1))
                push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        else if (pick < 96)
        begin
            // resync at the tail: the next frame starts with its second sync byte
            send_bytes(build_random_frame(SYNC1_BYTE), 0, 16);
            send_bytes(build_random_frame(random_tail()), 1, 15);
        end
        else
            drain();
    endtask

    // result side: random stalls per item, or one long hold-off when asked
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_stalls_on ? $urandom_range(0, 19) : 0;
            if (hold_len > 0)
            begin
                stall = hold_len;
                hold_len = 0;
            end
            if (stall > 0)
            begin
                @(negedge clk) result_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [7:0]  phase_timeout [7];
        logic [79:0] body;
        int          target;
        int          p;
        int          waited;

        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.cmd <= CMD_BYTE;
        item_ch.rx_byte <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        hold_len = 0;
        items_sent = 0;

        // reset value first, then the extremes, zero, a small one and a random one
        phase_timeout[0] = TIMEOUT_RESET;
        phase_timeout[1] = 8'd1;
        phase_timeout[2] = 8'd255;
        phase_timeout[3] = 8'd0;
        phase_timeout[4] = 8'd3;
        phase_timeout[5] = 8'($urandom_range(2, 254));
        phase_timeout[6] = TIMEOUT_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: idle tick, idle byte, sync repeated in place of the second
        // sync, sync in place of the control byte, then a good frame whose
        // payload holds sync, tail and extreme bytes, then a consuming tick
        // and an idle tick
        push_item(CMD_TICK, 8'hA5);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, SYNC1_BYTE);
        push_item(CMD_BYTE, SYNC1_BYTE);
        push_item(CMD_BYTE, SYNC2_BYTE);
        push_item(CMD_BYTE, SYNC1_BYTE);
        body = 80'h00FF557F8001AA55FF00;
        send_bytes({TAIL_BYTE, SYNC1_BYTE, frame_crc(body), body,
                    CTRL_RX_BYTE, SYNC2_BYTE, SYNC1_BYTE}, 1, 15);
        push_item(CMD_TICK, 8'h00);
        push_item(CMD_TICK, 8'hFF);

        for (p = 0; p < 7; p++)
        begin
            if (p > 0)
                write_timeout(phase_timeout[p]);
            tx_gaps_on = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            // back-pressure: receiver holds off while the sender keeps offering
            if (p == 1)
            begin
                tx_gaps_on = 1'b0;
                hold_len = HOLD_CYCLES;
            end
            target = items_sent + PHASE_ITEMS;
            // silence count saturates at the largest timeout
            if (phase_timeout[p] == 8'd255)
            begin
                repeat (LONG_TICK_RUN) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
                target = target + LONG_TICK_RUN;
            end
            while (items_sent < target)
                random_chunk();
        end

        @(negedge clk) item_ch.valid <= 1'b0;
        waited = 0;
        while (owed != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0 && owed == 0)
            $display("PASS crc8_serial_frame_receiver_core");
        else
            $display("FAIL crc8_serial_frame_receiver_core");
        $finish;
    end

endmodule
